// ===== design/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// shared types and constants for the best-fit segment allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int SIZE_W           = 21;
    localparam int OWNER_W          = 16;
    localparam int INDEX_W          = 6;
    localparam int DEF_MAX_SEGMENTS = 64;

    localparam logic [SIZE_W-1:0] TOTAL_RESET = 21'h100000;

    typedef enum logic [1:0] {
        ST_GRANT      = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2
    } t_bfsa_status;

    typedef struct packed {
        logic [OWNER_W-1:0] owner_id;
        logic [SIZE_W-1:0]  request_size;
    } t_bfsa_req;

    typedef struct packed {
        t_bfsa_status       status;
        logic [INDEX_W-1:0] segment_index;
        logic [SIZE_W-1:0]  leftover_size;
    } t_bfsa_rsp;

    typedef struct packed {
        logic               occupied;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
    } t_seg_entry;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_END,
        S_PLACE
    } t_bfsa_state;

    typedef struct packed {
        logic init;
        logic scan_start;
        logic scan_rd;
        logic decide;
        logic shift_rd;
        logic place;
        logic load_out;
    } t_bfsa_cmd;

    typedef struct packed {
        logic scan_last;
        logic shift_last;
        logic grant;
        logic out_busy;
        logic done_pending;
    } t_bfsa_sts;

endpackage

// ===== design/bfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsa_ctrl
// sequencer for table restart, best-fit scan, entry shift and insertion
// ----------------------------------------------------------------------------
module bfsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_cfg_wr_en,
    input  bfsa_pkg::t_bfsa_sts i_sts,
    output bfsa_pkg::t_bfsa_cmd o_cmd,
    output logic               o_req_stall
);
    import bfsa_pkg::*;

    t_bfsa_state r_state;
    t_bfsa_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_stall = 1'b1;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (!i_cfg_wr_en) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_sts.done_pending) begin
                    // previous result still waiting for the output register
                    if (!i_sts.out_busy) begin
                        o_cmd.load_out = 1'b1;
                    end
                end else if (i_cfg_wr_en) begin
                    n_state = S_INIT;
                end else begin
                    o_req_stall = 1'b0;
                    if (i_req_valid) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.grant ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_start |=> (r_state == S_SCAN))
        else $error("scan did not follow accept");
    a_shift_needs_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) && !i_sts.grant |=> (r_state == S_IDLE))
        else $error("refused request entered shift");
    a_place_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |-> ($past(r_state) == S_SHIFT_END))
        else $error("insert without shift");
`endif

endmodule

// ===== design/bfsa_dp.sv =====
// ----------------------------------------------------------------------------
// bfsa_dp
// segment table memory, scan compare, shift pipeline and result register
// ----------------------------------------------------------------------------
module bfsa_dp #(
    parameter int MAX_SEGMENTS = bfsa_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfsa_pkg::t_bfsa_cmd           i_cmd,
    output bfsa_pkg::t_bfsa_sts           o_sts,
    input  bfsa_pkg::t_bfsa_req           i_req_word,
    input  logic                          i_cfg_wr_en,
    input  logic [bfsa_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_stall,
    output bfsa_pkg::t_bfsa_rsp           o_rsp_word
);
    import bfsa_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    t_seg_entry        r_mem [MAX_SEGMENTS];
    t_seg_entry        r_rd_data;
    t_seg_entry        n_wr_data;
    logic [IW-1:0]     n_wr_addr;
    logic              n_wr_en;

    logic [SIZE_W-1:0] r_total;
    logic [CW-1:0]     r_count;
    logic [SIZE_W-1:0] r_req;
    logic [OWNER_W-1:0] r_owner;
    logic [IW-1:0]     r_ptr;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [IW-1:0]     r_best;
    logic [SIZE_W-1:0] r_best_size;
    logic              r_wb_vld;
    logic              r_wb_last;
    logic [IW-1:0]     r_wb_idx;
    logic [SIZE_W-1:0] r_leftover;
    t_bfsa_status      r_status;
    logic              r_done;
    logic              r_rsp_vld;
    t_bfsa_rsp         r_rsp;

    logic              full;
    logic              cand;

    assign full = (r_count == CW'(MAX_SEGMENTS));
    assign cand = !r_rd_data.occupied && (r_rd_data.size >= r_req);

    assign o_sts.scan_last    = (r_ptr == IW'(r_count - CW'(1)));
    assign o_sts.shift_last   = (r_ptr == r_best);
    assign o_sts.grant        = r_found && !full;
    assign o_sts.out_busy     = r_rsp_vld && i_rsp_stall;
    assign o_sts.done_pending = r_done;

    // table memory
    always_comb begin
        n_wr_en   = i_cmd.init || i_cmd.place || r_wb_vld;
        n_wr_addr = r_wb_idx;
        n_wr_data = r_rd_data;
        if (i_cmd.init) begin
            n_wr_addr      = '0;
            n_wr_data      = '0;
            n_wr_data.size = r_total;
        end else if (i_cmd.place) begin
            n_wr_addr          = r_best;
            n_wr_data.occupied = 1'b1;
            n_wr_data.size     = r_req;
            n_wr_data.owner    = r_owner;
        end else if (r_wb_last) begin
            n_wr_data.size = r_leftover;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd || i_cmd.shift_rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOTAL_RESET;
            r_count   <= CW'(1);
            r_found   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_wb_last <= 1'b0;
            r_done    <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            r_cmp_vld <= i_cmd.scan_rd;
            r_wb_vld  <= i_cmd.shift_rd;
            r_wb_last <= i_cmd.shift_rd && o_sts.shift_last;
            if (i_cmd.init) begin
                r_count <= CW'(1);
                r_found <= 1'b0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_found <= 1'b0;
            end else if (r_cmp_vld && cand &&
                         (!r_found || (r_rd_data.size < r_best_size))) begin
                r_found <= 1'b1;
            end
            if (i_cmd.decide && !o_sts.grant) begin
                r_done <= 1'b1;
            end else if (i_cmd.place) begin
                r_done <= 1'b1;
            end else if (i_cmd.load_out) begin
                r_done <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_rsp_vld <= 1'b1;
            end else if (r_rsp_vld && !i_rsp_stall) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_req   <= i_req_word.request_size;
            r_owner <= i_req_word.owner_id;
            r_ptr   <= '0;
        end else if (i_cmd.scan_rd) begin
            r_ptr <= r_ptr + IW'(1);
        end else if (i_cmd.decide) begin
            r_ptr <= IW'(r_count - CW'(1));
        end else if (i_cmd.shift_rd) begin
            r_ptr <= r_ptr - IW'(1);
        end
        r_cmp_idx <= r_ptr;
        r_wb_idx  <= r_ptr + IW'(1);
        if (r_cmp_vld && cand && (!r_found || (r_rd_data.size < r_best_size))) begin
            r_best      <= r_cmp_idx;
            r_best_size <= r_rd_data.size;
        end
        if (i_cmd.decide) begin
            r_leftover <= r_best_size - r_req;
            if (!r_found) begin
                r_status <= ST_NO_FIT;
            end else if (full) begin
                r_status <= ST_TABLE_FULL;
            end else begin
                r_status <= ST_GRANT;
            end
        end
        if (i_cmd.load_out) begin
            r_rsp.status <= r_status;
            if (r_status == ST_GRANT) begin
                r_rsp.segment_index <= INDEX_W'(r_best);
                r_rsp.leftover_size <= r_leftover;
            end else begin
                r_rsp.segment_index <= '0;
                r_rsp.leftover_size <= '0;
            end
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp_word  = r_rsp;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");
    a_best_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> ({1'b0, r_best} < {1'b0, r_count}))
        else $error("best fit beyond table end");
    a_place_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> !r_wb_vld)
        else $error("write port collision on insert");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_rsp_vld && i_rsp_stall))
        else $error("result register overwritten");
`endif

endmodule

// ===== design/best_fit_segment_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_unit
// best-fit allocator over an address-ordered segment table
//
// channel  dir  valid        stall        word
// request  in   i_req_valid  o_req_stall  i_req_word    (owner_id, request_size)
// result   out  o_rsp_valid  i_rsp_stall  o_rsp_word    (status, segment_index,
//                                                        leftover_size)
// config   in   i_cfg_wr_en  -            i_cfg_wr_data (total_memory)
//
// a request scans every table entry; a granted one then moves the entries
// from the best fit upward one slot up and writes itself in; the table
// memory scans one entry a cycle, then moves one entry a cycle to open a slot
// reset, and a config write taken while idle with no result pending,
// rewrite entry 0 as a free segment of total_memory; requests wait meanwhile
// a finished result waits until the output register is free, then moves in;
// the next word is taken as soon as the previous result has moved into that register
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = bfsa_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  bfsa_pkg::t_bfsa_req         i_req_word,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output bfsa_pkg::t_bfsa_rsp         o_rsp_word,
    input  logic                        i_cfg_wr_en,
    input  logic [bfsa_pkg::SIZE_W-1:0] i_cfg_wr_data
);
    import bfsa_pkg::*;

    t_bfsa_cmd cmd;
    t_bfsa_sts sts;

    bfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    bfsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_word    (i_req_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp_word    (o_rsp_word)
    );

endmodule
